// ===== rtl/prnf_pkg.sv =====
// ----------------------------------------------------------------------------
// prnf_pkg: shared types and constants for the padded radix number formatter
// Word layouts, the job record passed from the divider to the emitter,
// and the digit character table.
// ----------------------------------------------------------------------------
package prnf_pkg;

  localparam int unsigned DataW        = 32;                  // value width
  localparam int unsigned RadixW       = 5;
  localparam int unsigned WidthW       = 6;
  localparam int unsigned CharW        = 8;
  localparam int unsigned DigitW       = 4;                   // base <= 16
  localparam int unsigned NumDigits    = DataW;               // base 2 worst case
  localparam int unsigned DigIdxW      = $clog2(NumDigits);
  localparam int unsigned NdW          = $clog2(NumDigits + 1);
  localparam int unsigned DigitSlots   = 64;                  // top of MAX_DIGITS range
  localparam int unsigned LenW         = $clog2(DigitSlots + 1);
  localparam int unsigned MaxDigitsDef = 32;

  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(16);

  // divider retires this many quotient bits per cycle
  localparam int unsigned ChunkBits  = 8;
  localparam int unsigned ChunkSteps = DataW / ChunkBits;
  localparam int unsigned StepW      = $clog2(ChunkSteps);

  localparam int unsigned InFieldsW = DataW + RadixW + WidthW + CharW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = CharW;

  localparam logic [CharW-1:0] DigitChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // one formatted number waiting to be emitted
  typedef struct packed {
    logic [NumDigits-1:0][DigitW-1:0] digits;  // least significant at index 0
    logic [NdW-1:0]                   nd;      // count of real digits
    logic [LenW-1:0]                  len;     // characters to emit
    logic [CharW-1:0]                 pad;
  } job_t;

endpackage

// ===== rtl/padded_radix_number_formatter.sv =====
// Timing: the divider retires 8 quotient bits per cycle, and each digit of
//   the value takes a full pass over all 32 bits; a finished job then goes
//   through the queue, emitter load and output register to its first character.
// Rate: the front takes no new word until the last is divided and pushed;
//   the emitter drains earlier jobs meanwhile, and the slower side sets the rate.
// A word with a base outside 2..16 is taken and emits nothing.
// Reset (rst_ni low, async) empties the queue and idles both sides.
// ----------------------------------------------------------------------------
// padded_radix_number_formatter: unsigned integer to padded digit string
// The front divides the value by the base digit by digit; a two-entry queue
// holds finished jobs; the back emits characters most significant first.
// ----------------------------------------------------------------------------
module padded_radix_number_formatter
  import prnf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] number, [36:32] radix, [42:37] min_width, [50:43] pad_char, zero fill
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // output words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] char_code
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tlast      // last character of a number
);

  localparam int unsigned RadixLo = DataW;
  localparam int unsigned WidthLo = RadixLo + RadixW;
  localparam int unsigned PadLo   = WidthLo + WidthW;

  logic job_wr_valid, job_wr_ready;
  logic job_rd_valid, job_rd_ready;
  job_t job_wr, job_rd;

  prnf_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .number_i    (s_axis_tdata[DataW-1:0]),
    .radix_i     (s_axis_tdata[RadixLo +: RadixW]),
    .min_width_i (s_axis_tdata[WidthLo +: WidthW]),
    .pad_char_i  (s_axis_tdata[PadLo +: CharW]),
    .job_valid_o (job_wr_valid),
    .job_ready_i (job_wr_ready),
    .job_o       (job_wr)
  );

  prnf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_wr_valid),
    .wr_ready_o (job_wr_ready),
    .wr_job_i   (job_wr),
    .rd_valid_o (job_rd_valid),
    .rd_ready_i (job_rd_ready),
    .rd_job_o   (job_rd)
  );

  prnf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_rd_valid),
    .job_ready_o (job_rd_ready),
    .job_i       (job_rd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .char_code_o (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

// ===== rtl/prnf_front.sv =====
// ----------------------------------------------------------------------------
// prnf_front: input side of the formatter
// Accepts a word, drops bad bases, peels digits off by repeated long
// division and hands a finished job to the queue.
// ----------------------------------------------------------------------------
module prnf_front
  import prnf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DataW-1:0]    number_i,
  input  logic [RadixW-1:0]   radix_i,
  input  logic [WidthW-1:0]   min_width_i,
  input  logic [CharW-1:0]    pad_char_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output job_t                job_o
);

  typedef enum logic [2:0] {
    FeIdle = 3'b001,
    FeDiv  = 3'b010,
    FePush = 3'b100
  } fe_state_e;

  fe_state_e state_q, state_d;

  logic [DataW-1:0]                 work_q, work_d;   // dividend, then quotient
  logic [RadixW-1:0]                rem_q, rem_d;
  logic [RadixW-1:0]                radix_q;
  logic [StepW-1:0]                 step_q, step_d;
  logic [NdW-1:0]                   nd_q, nd_d;
  logic [LenW-1:0]                  width_q;
  logic [CharW-1:0]                 pad_q;
  logic [NumDigits-1:0][DigitW-1:0] dig_q;

  logic                  accept;
  logic                  radix_ok;
  logic [LenW-1:0]       width_sat;
  logic [RadixW-1:0]     rem_new;
  logic [ChunkBits-1:0]  qbits;
  logic [DataW-1:0]      work_shift;
  logic                  digit_done;

  assign in_ready_o = (state_q == FeIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign radix_ok   = (radix_i >= RadixMin) && (radix_i <= RadixMax);
  assign width_sat  = (LenW'(min_width_i) > LenW'(MAX_DIGITS)) ?
                      LenW'(MAX_DIGITS) : LenW'(min_width_i);

  // restoring division, ChunkBits quotient bits per cycle
  always_comb begin
    logic [RadixW-1:0] r;
    r = rem_q;
    for (int i = 0; i < ChunkBits; i++) begin
      r = {r[RadixW-2:0], work_q[DataW-1-i]};
      qbits[ChunkBits-1-i] = (r >= radix_q);
      if (r >= radix_q) begin
        r = r - radix_q;
      end
    end
    rem_new = r;
  end

  assign work_shift = {work_q[DataW-ChunkBits-1:0], qbits};
  assign digit_done = (step_q == StepW'(ChunkSteps - 1));

  always_comb begin
    state_d = state_q;
    work_d  = work_q;
    rem_d   = rem_q;
    step_d  = step_q;
    nd_d    = nd_q;
    case (state_q)
      FeIdle: begin
        if (accept && radix_ok) begin
          state_d = FeDiv;
          work_d  = number_i;
          rem_d   = '0;
          step_d  = '0;
          nd_d    = '0;
        end
      end
      FeDiv: begin
        work_d = work_shift;
        step_d = step_q + StepW'(1);
        rem_d  = rem_new;
        if (digit_done) begin
          nd_d  = nd_q + NdW'(1);
          rem_d = '0;
          if (work_shift == '0) begin
            state_d = FePush;
          end
        end
      end
      FePush: begin
        if (job_ready_i) begin
          state_d = FeIdle;
        end
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      step_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (accept) begin
      radix_q <= radix_i;
      width_q <= width_sat;
      pad_q   <= pad_char_i;
    end
    if (state_q == FeDiv && digit_done) begin
      dig_q[nd_q[DigIdxW-1:0]] <= rem_new[DigitW-1:0];
    end
  end

  assign job_valid_o = (state_q == FePush);
  assign job_o.digits = dig_q;
  assign job_o.nd     = nd_q;
  assign job_o.len    = (LenW'(nd_q) > width_q) ? LenW'(nd_q) : width_q;
  assign job_o.pad    = pad_q;

endmodule

// ===== rtl/prnf_fifo.sv =====
// ----------------------------------------------------------------------------
// prnf_fifo: two-entry job queue
// Decouples the divider from the character emitter.
// ----------------------------------------------------------------------------
module prnf_fifo
  import prnf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_job_o
);

  localparam int unsigned Depth = 2;

  job_t         mem_q [Depth];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign wr_ready_o = (cnt_q != 2'(Depth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

// ===== rtl/prnf_back.sv =====
// ----------------------------------------------------------------------------
// prnf_back: character emitter
// Walks a job from the most significant position down, one character
// per cycle unless the output is held back, into a registered output word.
// ----------------------------------------------------------------------------
module prnf_back
  import prnf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  job_t                 job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CharW-1:0]     char_code_o,
  output logic                 last_o
);

  logic             busy_q;
  job_t             job_q;
  logic [LenW-1:0]  pos_q;
  logic             oval_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  logic             slot_free;
  logic             emit;
  logic [CharW-1:0] char_d;

  assign job_ready_o = !busy_q;
  assign slot_free   = !oval_q || out_ready_i;
  assign emit        = busy_q && slot_free;

  // positions above the real digits are leading zeros and show the pad
  assign char_d = (pos_q >= LenW'(job_q.nd)) ? job_q.pad :
                  DigitChars[job_q.digits[pos_q[DigIdxW-1:0]]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (job_valid_i && !busy_q) begin
        busy_q <= 1'b1;
      end else if (emit && pos_q == '0) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && !busy_q) begin
      job_q <= job_i;
      pos_q <= job_i.len - LenW'(1);
    end else if (emit) begin
      pos_q <= pos_q - LenW'(1);
    end
    if (emit) begin
      char_q <= char_d;
      last_q <= (pos_q == '0);
    end
  end

  assign out_valid_o = oval_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule
